// ===== hdl/cdq_pkg.sv =====
`default_nettype none

package cdq_pkg;

  // Word width and default ring depth
  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 8;

  // Operation codes carried by the mode field
  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_REAR  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_REAR   = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_OUT
  } ctl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic exec;
  } dp_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/cdq_ctrl.sv =====
`default_nettype none

module cdq_ctrl
  import cdq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output dp_cmd_t   cmd
);

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: take one transfer, then hold the result until it leaves
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Drive handshake and datapath commands
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    cmd.exec  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.exec = in_valid;
      end
      ST_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/cdq_datapath.sv =====
`default_nettype none

module cdq_datapath
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  dp_cmd_t                       cmd,
  input  wire logic [1:0]               in_mode,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic [1:0]                    out_status,
  output logic signed [DATA_W-1:0]      out_popped_value,
  output logic                          out_now_empty,
  output logic                          out_now_full
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i);
    step_up = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i);
    step_down = (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  logic [DATA_W-1:0] ring_mem [DEPTH];

  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic              vacant_r, vacant_nxt;
  logic [DATA_W-1:0] rd_data_r;
  logic              pop_ok_r, pop_ok_nxt;
  status_t           status_r, status_nxt;
  logic              empty_r, full_r;

  logic              is_push;
  logic              is_front;
  logic              full_now;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  rd_addr;

  assign is_push  = ~in_mode[1];
  assign is_front = (mode_t'(in_mode) == MODE_PUSH_FRONT) ||
                    (mode_t'(in_mode) == MODE_POP_FRONT);
  assign full_now = ~vacant_r && (step_up(tail_r) == head_r);
  assign rd_addr  = is_front ? head_r : tail_r;

  // Work out the step: index moves, store write and status
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    vacant_nxt = vacant_r;
    wr_en      = 1'b0;
    wr_addr    = '0;
    pop_ok_nxt = 1'b0;
    status_nxt = STAT_DONE;
    if (is_push) begin
      if (full_now) begin
        status_nxt = STAT_FULL;
      end else if (vacant_r) begin
        head_nxt   = '0;
        tail_nxt   = '0;
        vacant_nxt = 1'b0;
        wr_en      = 1'b1;
        wr_addr    = '0;
      end else if (is_front) begin
        head_nxt = step_down(head_r);
        wr_en    = 1'b1;
        wr_addr  = step_down(head_r);
      end else begin
        tail_nxt = step_up(tail_r);
        wr_en    = 1'b1;
        wr_addr  = step_up(tail_r);
      end
    end else begin
      if (vacant_r) begin
        status_nxt = STAT_EMPTY;
      end else begin
        pop_ok_nxt = 1'b1;
        if (head_r == tail_r) begin
          vacant_nxt = 1'b1;
        end else if (is_front) begin
          head_nxt = step_up(head_r);
        end else begin
          tail_nxt = step_down(tail_r);
        end
      end
    end
  end

  // Update indices and empty flag on each executed transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      vacant_r <= 1'b1;
    end else if (cmd.exec) begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      vacant_r <= vacant_nxt;
    end
  end

  // Ring store: at most one write and one registered read per step
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      ring_mem[wr_addr] <= in_value;
    end
    if (cmd.exec) begin
      rd_data_r <= ring_mem[rd_addr];
    end
  end

  // Capture the result fields
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pop_ok_r <= pop_ok_nxt;
      status_r <= status_nxt;
      empty_r  <= vacant_nxt;
      full_r   <= ~vacant_nxt && (step_up(tail_nxt) == head_nxt);
    end
  end

  assign out_status       = status_r;
  assign out_popped_value = pop_ok_r ? $signed(rd_data_r) : '0;
  assign out_now_empty    = empty_r;
  assign out_now_full     = full_r;

endmodule

`default_nettype wire

// ===== hdl/circular_deque.sv =====
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  in_mode, in_value
// out_     output     out_valid/out_stall out_status, out_popped_value,
//                                         out_now_empty, out_now_full
//
// The transfer cycle runs the operation and the registered ring read, and
// the next cycle shows the result.
// A stalled result holds the block; the next transfer follows its delivery.
// Synchronous active-low reset empties the deque; no clearing pass is needed.
`default_nettype none

module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               in_mode,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [1:0]                    out_status,
  output logic signed [DATA_W-1:0]      out_popped_value,
  output logic                          out_now_empty,
  output logic                          out_now_full
);

  dp_cmd_t cmd;

  // Sequence transfers
  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Hold ring, indices and result
  cdq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_mode          (in_mode),
    .in_value         (in_value),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_now_empty    (out_now_empty),
    .out_now_full     (out_now_full)
  );

endmodule

`default_nettype wire

// ===== hdl/cdq_checker.sv =====
`default_nettype none

module cdq_checker
  import cdq_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_valid,
  input wire logic                     in_stall,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic [1:0]               out_status,
  input wire logic signed [DATA_W-1:0] out_popped_value,
  input wire logic                     out_now_empty,
  input wire logic                     out_now_full
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_popped_value) && $stable(out_now_empty) && $stable(out_now_full))
    else $error("stalled result changed");

  // Every accepted transfer shows its result in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("result missing after input transfer");

  // A refused push means the deque stays full
  a_full_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_FULL) |-> out_now_full && !out_now_empty &&
      (out_popped_value == '0))
    else $error("full refusal with inconsistent flags");

  // A refused pop means the deque stays empty
  a_empty_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_EMPTY) |-> out_now_empty && !out_now_full &&
      (out_popped_value == '0))
    else $error("empty refusal with inconsistent flags");

  // Empty and full never show together
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_now_empty && out_now_full))
    else $error("empty and full both set");

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);

`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none

module tb_top;
  import cdq_pkg::*;

  localparam int RING_DEPTH  = DEPTH_DEF;
  localparam int IDX_W       = $clog2(RING_DEPTH);
  localparam int RANDOM_OPS  = 1927;
  localparam int QUIET_OPS   = 250;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] popped;
    logic              now_empty;
    logic              now_full;
  } deque_result_t;

  typedef struct packed {
    mode_t             op;
    logic [DATA_W-1:0] word;
    logic              typed;
    deque_result_t     want;
  } stim_row_t;

  // Results that can be read straight off the behavior
  localparam deque_result_t R_EMPTY_REFUSED = '{STAT_EMPTY, 32'h0, 1'b1, 1'b0};
  localparam deque_result_t R_FULL_REFUSED  = '{STAT_FULL, 32'h0, 1'b0, 1'b1};
  localparam deque_result_t R_PUSHED        = '{STAT_DONE, 32'h0, 1'b0, 1'b0};
  localparam deque_result_t R_LAST_POPPED   = '{STAT_DONE, 32'h7fffffff, 1'b1, 1'b0};
  localparam deque_result_t R_FROM_SHADOW   = '{STAT_DONE, 32'h0, 1'b0, 1'b0};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_mode = MODE_PUSH_FRONT;
  logic [DATA_W-1:0] in_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_status;
  logic [DATA_W-1:0] out_popped_value;
  logic              out_now_empty;
  logic              out_now_full;

  // Shadow copy of the deque
  logic [DATA_W-1:0] shadow_ring [RING_DEPTH];
  logic [IDX_W-1:0]  shadow_head = '0;
  logic [IDX_W-1:0]  shadow_tail = '0;
  logic              shadow_vacant = 1'b1;

  deque_result_t pending_results [$];

  int fail_count    = 0;
  int cycle_count   = 0;
  int gap_pct       = 0;
  int stall_pct     = 0;
  int stall_left    = 0;
  int ops_sent      = 0;
  int refused_full  = 0;
  int refused_empty = 0;
  int words_popped  = 0;

  // Refuse on empty, fill, overflow, then drain from both ends and refuse again
  stim_row_t directed_ops [23] = '{
    '{MODE_POP_FRONT,  32'h00000000, 1'b1, R_EMPTY_REFUSED},
    '{MODE_POP_REAR,   32'hffffffff, 1'b1, R_EMPTY_REFUSED},
    '{MODE_PUSH_FRONT, 32'h7fffffff, 1'b1, R_PUSHED},
    '{MODE_POP_REAR,   32'h00000000, 1'b1, R_LAST_POPPED},
    '{MODE_PUSH_REAR,  32'h80000000, 1'b1, R_PUSHED},
    '{MODE_PUSH_FRONT, 32'hffffffff, 1'b0, R_FROM_SHADOW},
    '{MODE_PUSH_REAR,  32'h00000000, 1'b0, R_FROM_SHADOW},
    '{MODE_PUSH_FRONT, 32'h00000001, 1'b0, R_FROM_SHADOW},
    '{MODE_PUSH_REAR,  32'h55555555, 1'b0, R_FROM_SHADOW},
    '{MODE_PUSH_FRONT, 32'haaaaaaaa, 1'b0, R_FROM_SHADOW},
    '{MODE_PUSH_REAR,  32'h12345678, 1'b0, R_FROM_SHADOW},
    '{MODE_PUSH_FRONT, 32'h87654321, 1'b0, R_FROM_SHADOW},
    '{MODE_PUSH_REAR,  32'h00000000, 1'b1, R_FULL_REFUSED},
    '{MODE_PUSH_FRONT, 32'hffffffff, 1'b1, R_FULL_REFUSED},
    '{MODE_POP_FRONT,  32'h00000000, 1'b0, R_FROM_SHADOW},
    '{MODE_POP_REAR,   32'h00000000, 1'b0, R_FROM_SHADOW},
    '{MODE_POP_FRONT,  32'hffffffff, 1'b0, R_FROM_SHADOW},
    '{MODE_POP_REAR,   32'h00000000, 1'b0, R_FROM_SHADOW},
    '{MODE_POP_FRONT,  32'h00000000, 1'b0, R_FROM_SHADOW},
    '{MODE_POP_REAR,   32'h00000000, 1'b0, R_FROM_SHADOW},
    '{MODE_POP_FRONT,  32'h00000000, 1'b0, R_FROM_SHADOW},
    '{MODE_POP_REAR,   32'h00000000, 1'b0, R_FROM_SHADOW},
    '{MODE_POP_REAR,   32'h00000000, 1'b1, R_EMPTY_REFUSED}
  };

  circular_deque #(
    .DEPTH(RING_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_now_empty    (out_now_empty),
    .out_now_full     (out_now_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [IDX_W-1:0] idx_up(logic [IDX_W-1:0] i);
    return (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_down(logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(RING_DEPTH - 1) : i - 1'b1;
  endfunction

  function automatic logic shadow_full();
    return !shadow_vacant && (idx_up(shadow_tail) == shadow_head);
  endfunction

  // Apply one operation to the shadow deque and return its result
  function automatic deque_result_t predict_deque_op(mode_t op, logic [DATA_W-1:0] word);
    deque_result_t r;
    r = '{STAT_DONE, '0, 1'b0, 1'b0};
    if (op == MODE_PUSH_FRONT || op == MODE_PUSH_REAR) begin
      if (shadow_full()) begin
        r.status = STAT_FULL;
      end else if (shadow_vacant) begin
        // first word always lands at entry zero
        shadow_head = '0;
        shadow_tail = '0;
        shadow_vacant = 1'b0;
        shadow_ring[0] = word;
      end else if (op == MODE_PUSH_FRONT) begin
        shadow_head = idx_down(shadow_head);
        shadow_ring[shadow_head] = word;
      end else begin
        shadow_tail = idx_up(shadow_tail);
        shadow_ring[shadow_tail] = word;
      end
    end else if (shadow_vacant) begin
      r.status = STAT_EMPTY;
    end else if (op == MODE_POP_FRONT) begin
      r.popped = shadow_ring[shadow_head];
      if (shadow_head == shadow_tail) shadow_vacant = 1'b1;
      else shadow_head = idx_up(shadow_head);
    end else begin
      r.popped = shadow_ring[shadow_tail];
      if (shadow_head == shadow_tail) shadow_vacant = 1'b1;
      else shadow_tail = idx_down(shadow_tail);
    end
    r.now_empty = shadow_vacant;
    r.now_full  = shadow_full();
    return r;
  endfunction

  // Drive one operation, hold it until the transfer, then record the expected result
  task automatic send_op(input mode_t op, input logic [DATA_W-1:0] word,
                         input logic typed, input deque_result_t want);
    deque_result_t predicted;
    @(negedge clk);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= op;
    in_value <= word;
    do @(posedge clk); while (in_stall);
    predicted = predict_deque_op(op, word);
    pending_results.push_back(typed ? want : predicted);
    ops_sent++;
    case (predicted.status)
      STAT_FULL:  refused_full++;
      STAT_EMPTY: refused_empty++;
      default:    if (op == MODE_POP_FRONT || op == MODE_POP_REAR) words_popped++;
    endcase
  endtask

  // Stall the result channel in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each result transfer against the oldest expectation
  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d popped %h",
                 $time, out_status, out_popped_value);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          fail_count++;
        end
        if (out_popped_value !== want.popped) begin
          $display("%0t: popped_value expected %h actual %h",
                   $time, want.popped, out_popped_value);
          fail_count++;
        end
        if (out_now_empty !== want.now_empty) begin
          $display("%0t: now_empty expected %0b actual %0b",
                   $time, want.now_empty, out_now_empty);
          fail_count++;
        end
        if (out_now_full !== want.now_full) begin
          $display("%0t: now_full expected %0b actual %0b", $time, want.now_full, out_now_full);
          fail_count++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("circular_deque regression: fail");
      $finish;
    end
  end

  initial begin
    int push_pct;
    mode_t op;
    logic [DATA_W-1:0] word;
    push_pct = 50;

    // Hold reset, then release at a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (directed_ops[i]) begin
      send_op(directed_ops[i].op, directed_ops[i].word, directed_ops[i].typed,
              directed_ops[i].want);
    end

    // Random mix: biased push or pop phases sweep between empty and full
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 20;
          1:       push_pct = 50;
          default: push_pct = 80;
        endcase
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 10;
          default: gap_pct = 35;
        endcase
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      if (n >= RANDOM_OPS - QUIET_OPS) begin
        gap_pct = 0;
        stall_pct = 0;
      end
      // Let the block drain completely once mid-run
      if (n == RANDOM_OPS / 2) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      if ($urandom_range(0, 99) < push_pct) op = mode_t'($urandom_range(0, 1));
      else op = mode_t'($urandom_range(2, 3));
      if ($urandom_range(0, 15) == 0) begin
        case ($urandom_range(0, 3))
          0:       word = 32'h00000000;
          1:       word = 32'h7fffffff;
          2:       word = 32'h80000000;
          default: word = 32'hffffffff;
        endcase
      end else begin
        word = $urandom;
      end
      send_op(op, word, 1'b0, R_FROM_SHADOW);
    end

    // Drop valid and wait out the last results
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d deque operations over %0d cycles with random gaps and stalls",
             ops_sent, cycle_count);
    $display("Popped %0d words, refused %0d pushes on full and %0d pops on empty",
             words_popped, refused_full, refused_empty);
    if (fail_count == 0) begin
      $display("circular_deque regression: pass");
    end else begin
      $display("circular_deque regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
